FILE: rtl/tce_pkg.sv
// Shared types and constants for the tile coverage enumerator.
`timescale 1ns / 1ps

package tce_pkg;

  // Field widths.
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned IDX_W  = 36;
  localparam int unsigned SMP_W  = 5;
  localparam int unsigned CSMP_W = 4;

  // Run limits.
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned MAX_SAMPLES = 16;
  localparam int unsigned RUN_W       = 7;
  localparam int unsigned PROD_W      = 2 * RUN_W;

  // Divider: 17-bit dividend covers a + b - 1 for the ceiling divisions.
  localparam int unsigned DIV_W     = DIM_W + 1;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned DCNT_W    = 5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATE_PLANES = 3'd5;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/tce_div.sv
// Restoring divider, one quotient bit per cycle, shared by all corner divisions.
`timescale 1ns / 1ps

module tce_div
  import tce_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIM_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIM_W-1:0]  dvs_q;
  logic [DIV_W-1:0]  trial;
  logic [DIV_W-1:0]  diff;
  logic              fits;

  // One trial subtraction per step.
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/tile_coverage_enumerator.sv
// Top level: request check, corner divisions and tile index run output.
//
//   Channel  Direction  Handshake                 Beat
//   in       input      in_valid_i / in_stall_o   region_x, region_y, region_w, region_h
//   out      output     out_valid_o / out_stall_i tile_index, error, last
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// The first index of a request is loaded after the check, six divisions on the shared
// divider, the run count and base products, and the load of the output register. Then
// one index leaves per cycle while the output is not stalled, up to 64. An empty or
// out-of-image request gives its error beat after the check; a run over the limit is
// refused after the divisions, also with an error beat.
// Reset idles the sequencer and empties the output; image and tile sizes reset to one.
// A stalled output holds its beat; the next request is taken once the last beat is loaded.
`timescale 1ns / 1ps

module tile_coverage_enumerator
  import tce_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DIM_W-1:0]     region_x_i,
  input  logic [DIM_W-1:0]     region_y_i,
  input  logic [DIM_W-1:0]     region_w_i,
  input  logic [DIM_W-1:0]     region_h_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     tile_index_o,
  output logic                 error_o,
  output logic                 last_o,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV_GO, S_DIV_WAIT, S_COUNT, S_SCALE,
    S_MUL_ROW, S_MUL_PLANE, S_EMIT, S_REFUSE
  } state_e;

  typedef enum logic [2:0] {
    OP_COL_START, OP_COL_END, OP_ROW_START, OP_ROW_END, OP_TILES_ACROSS, OP_TILES_DOWN
  } div_op_e;

  state_e  state_q;
  div_op_e op_q;

  // Configuration registers.
  logic [DIM_W-1:0] img_w_q, img_h_q, tile_w_q, tile_h_q;
  logic [SMP_W-1:0] smp_cnt_q;
  logic             sep_q;

  // Request and range registers.
  logic [DIM_W-1:0]  rx_q, ry_q, rw_q, rh_q;
  logic [DIM_W-1:0]  xr_q, yb_q;
  logic [DIM_W-1:0]  cs_q, ce_q, rs_q, re_q;
  logic [DIM_W-1:0]  tpr_q, down_q;
  logic [PROD_W-1:0] prod_q;
  logic [2*DIM_W-1:0] per_plane_q;
  logic [IDX_W-1:0]  plane_base_q, row_base_q;
  logic [DIM_W-1:0]  cur_col_q, cur_row_q;
  logic [CSMP_W-1:0] cur_smp_q;

  // Output register.
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_err_q;
  logic             out_last_q;

  // Combinational helpers.
  logic [DIM_W-1:0]   eff_tw, eff_th;
  logic [DIV_W-1:0]   xr_sum, yb_sum;
  logic               refuse_now;
  logic [SMP_W-1:0]   slim;
  logic [DIV_W-1:0]   ncols, nrows;
  logic [PROD_W+SMP_W-1:0] run_len;
  logic [2*DIM_W-1:0] row_off, plane_sz;
  logic [IDX_W-1:0]   cur_idx;
  logic               at_col_end, at_row_end, at_smp_end, at_last;
  logic               slot_free;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Zero tile sizes act as one; sample planes are one unless planes are separate, and saturate to the limit.
  always_comb begin
    eff_tw = (tile_w_q == '0) ? DIM_W'(1) : tile_w_q;
    eff_th = (tile_h_q == '0) ? DIM_W'(1) : tile_h_q;
    if (!sep_q || smp_cnt_q == '0) begin
      slim = SMP_W'(1);
    end else if (smp_cnt_q > SMP_W'(MAX_SAMPLES)) begin
      slim = SMP_W'(MAX_SAMPLES);
    end else begin
      slim = smp_cnt_q;
    end
  end

  // Request bounds check.
  always_comb begin
    xr_sum     = {1'b0, rx_q} + {1'b0, rw_q} - DIV_W'(1);
    yb_sum     = {1'b0, ry_q} + {1'b0, rh_q} - DIV_W'(1);
    refuse_now = (rw_q == '0) || (rh_q == '0) ||
                 (xr_sum >= {1'b0, img_w_q}) || (yb_sum >= {1'b0, img_h_q});
  end

  // Run length and base products.
  always_comb begin
    ncols    = {1'b0, ce_q} - {1'b0, cs_q} + DIV_W'(1);
    nrows    = {1'b0, re_q} - {1'b0, rs_q} + DIV_W'(1);
    run_len  = {{SMP_W{1'b0}}, prod_q} * {{PROD_W{1'b0}}, slim};
    row_off  = {{DIM_W{1'b0}}, rs_q} * {{DIM_W{1'b0}}, tpr_q};
    plane_sz = {{DIM_W{1'b0}}, tpr_q} * {{DIM_W{1'b0}}, down_q};
  end

  // Enumeration position.
  always_comb begin
    cur_idx    = row_base_q + {{(IDX_W-DIM_W){1'b0}}, cur_col_q};
    at_col_end = (cur_col_q == ce_q);
    at_row_end = (cur_row_q == re_q);
    at_smp_end = ({1'b0, cur_smp_q} == (slim - SMP_W'(1)));
    at_last    = at_col_end && at_row_end && at_smp_end;
    slot_free  = !out_valid_q || !out_stall_i;
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_req.start = (state_q == S_DIV_GO);
    unique case (op_q)
      OP_COL_START: begin
        div_req.dividend = {1'b0, rx_q};
        div_req.divisor  = eff_tw;
      end
      OP_COL_END: begin
        div_req.dividend = {1'b0, xr_q};
        div_req.divisor  = eff_tw;
      end
      OP_ROW_START: begin
        div_req.dividend = {1'b0, ry_q};
        div_req.divisor  = eff_th;
      end
      OP_ROW_END: begin
        div_req.dividend = {1'b0, yb_q};
        div_req.divisor  = eff_th;
      end
      OP_TILES_ACROSS: begin
        div_req.dividend = {1'b0, img_w_q} + {1'b0, eff_tw} - DIV_W'(1);
        div_req.divisor  = eff_tw;
      end
      OP_TILES_DOWN: begin
        div_req.dividend = {1'b0, img_h_q} + {1'b0, eff_th} - DIV_W'(1);
        div_req.divisor  = eff_th;
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = DIM_W'(1);
      end
    endcase
  end

  tce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= DIM_W'(1);
      img_h_q   <= DIM_W'(1);
      tile_w_q  <= DIM_W'(1);
      tile_h_q  <= DIM_W'(1);
      smp_cnt_q <= SMP_W'(1);
      sep_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:     img_w_q   <= cfg_data_i;
        CFG_IMAGE_HEIGHT:    img_h_q   <= cfg_data_i;
        CFG_TILE_WIDTH:      tile_w_q  <= cfg_data_i;
        CFG_TILE_HEIGHT:     tile_h_q  <= cfg_data_i;
        CFG_SAMPLE_COUNT:    smp_cnt_q <= cfg_data_i[SMP_W-1:0];
        CFG_SEPARATE_PLANES: sep_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer with its working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_COL_START;
      rx_q         <= '0;
      ry_q         <= '0;
      rw_q         <= '0;
      rh_q         <= '0;
      xr_q         <= '0;
      yb_q         <= '0;
      cs_q         <= '0;
      ce_q         <= '0;
      rs_q         <= '0;
      re_q         <= '0;
      tpr_q        <= DIM_W'(1);
      down_q       <= DIM_W'(1);
      prod_q       <= '0;
      per_plane_q  <= '0;
      plane_base_q <= '0;
      row_base_q   <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      cur_smp_q    <= '0;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_err_q    <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      // The output register loads a new beat, or empties once its beat is taken.
      if (slot_free && (state_q == S_EMIT || state_q == S_REFUSE)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            rx_q    <= region_x_i;
            ry_q    <= region_y_i;
            rw_q    <= region_w_i;
            rh_q    <= region_h_i;
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          xr_q <= xr_sum[DIM_W-1:0];
          yb_q <= yb_sum[DIM_W-1:0];
          op_q <= OP_COL_START;
          if (refuse_now) begin
            state_q <= S_REFUSE;
          end else begin
            state_q <= S_DIV_GO;
          end
        end

        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            unique case (op_q)
              OP_COL_START:    cs_q   <= div_rsp.quotient[DIM_W-1:0];
              OP_COL_END:      ce_q   <= div_rsp.quotient[DIM_W-1:0];
              OP_ROW_START:    rs_q   <= div_rsp.quotient[DIM_W-1:0];
              OP_ROW_END:      re_q   <= div_rsp.quotient[DIM_W-1:0];
              OP_TILES_ACROSS: tpr_q  <= div_rsp.quotient[DIM_W-1:0];
              OP_TILES_DOWN:   down_q <= div_rsp.quotient[DIM_W-1:0];
              default: ;
            endcase
            if (op_q == OP_TILES_DOWN) begin
              state_q <= S_COUNT;
            end else begin
              op_q    <= div_op_e'(op_q + 3'd1);
              state_q <= S_DIV_GO;
            end
          end
        end

        // Tile columns times rows, each first bounded by the run limit.
        S_COUNT: begin
          if (ncols > DIV_W'(MAX_RUN) || nrows > DIV_W'(MAX_RUN)) begin
            state_q <= S_REFUSE;
          end else begin
            prod_q  <= {{RUN_W{1'b0}}, ncols[RUN_W-1:0]} *
                       {{RUN_W{1'b0}}, nrows[RUN_W-1:0]};
            state_q <= S_SCALE;
          end
        end

        S_SCALE: begin
          if (run_len > (PROD_W+SMP_W)'(MAX_RUN)) begin
            state_q <= S_REFUSE;
          end else begin
            state_q <= S_MUL_ROW;
          end
        end

        S_MUL_ROW: begin
          plane_base_q <= {{(IDX_W-2*DIM_W){1'b0}}, row_off};
          row_base_q   <= {{(IDX_W-2*DIM_W){1'b0}}, row_off};
          state_q      <= S_MUL_PLANE;
        end

        S_MUL_PLANE: begin
          per_plane_q <= plane_sz;
          cur_col_q   <= cs_q;
          cur_row_q   <= rs_q;
          cur_smp_q   <= '0;
          state_q     <= S_EMIT;
        end

        // One index per free output slot: column, then row, then sample plane.
        S_EMIT: begin
          if (slot_free) begin
            out_idx_q   <= cur_idx;
            out_err_q   <= 1'b0;
            out_last_q  <= at_last;
            if (at_last) begin
              state_q <= S_IDLE;
            end else if (!at_col_end) begin
              cur_col_q <= cur_col_q + DIM_W'(1);
            end else if (!at_row_end) begin
              cur_col_q  <= cs_q;
              cur_row_q  <= cur_row_q + DIM_W'(1);
              row_base_q <= row_base_q + {{(IDX_W-DIM_W){1'b0}}, tpr_q};
            end else begin
              cur_col_q    <= cs_q;
              cur_row_q    <= rs_q;
              cur_smp_q    <= cur_smp_q + CSMP_W'(1);
              plane_base_q <= plane_base_q + {{(IDX_W-2*DIM_W){1'b0}}, per_plane_q};
              row_base_q   <= plane_base_q + {{(IDX_W-2*DIM_W){1'b0}}, per_plane_q};
            end
          end
        end

        S_REFUSE: begin
          if (slot_free) begin
            out_idx_q   <= '0;
            out_err_q   <= 1'b1;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign tile_index_o = out_idx_q;
  assign error_o      = out_err_q;
  assign last_o       = out_last_q;

endmodule
